/* hw/rtl/shbt_pkg.sv */
// Shared types and constants of the spatial hash broadphase table.
// Used by the controller, the datapath, the top level and the checker.
package shbt_pkg;

    localparam int InDataW  = 72;   // input tdata width, padded to bytes
    localparam int OutDataW = 104;  // output tdata width, padded to bytes

    // Hash primes, all below 2**27.
    localparam logic [26:0] HashX = 27'd73856093;
    localparam logic [26:0] HashY = 27'd19349663;
    localparam logic [26:0] HashZ = 27'd83492791;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_PAIR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DUP        = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_POOL_FULL  = 3'd3,
        ST_NO_SLOT    = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE, S_CLEAR, S_WRAP,
        S_MUL0, S_MUL1, S_MUL2,
        S_PRB_SET, S_PRB_RD, S_PRB_CHK,
        S_DUP, S_DUP_CHK, S_ADD,
        S_RD_LIST, S_RD_BKT, S_RD_WAIT, S_RD_OUT,
        S_PS_CLR, S_PS_SLOT, S_PS_LW, S_PS_LB, S_PS_BW, S_PS_BCHK,
        S_PS_GW, S_PS_G, S_PS_PAIR, S_PS_XY, S_PS_IDX, S_PS_SW, S_PS_SCHK,
        S_DONE
    } t_state;

    typedef enum logic [5:0] {
        A_IDLE, A_TSWEEP, A_LOAD, A_CLEAR,
        A_MUL0, A_MUL1, A_MUL2,
        A_PRB_SET, A_PRB_NEXT, A_CLAIM, A_FOUND, A_TFULL,
        A_DUP_NEXT, A_DUP, A_POOLFULL, A_ADD,
        A_RD_BAD, A_RD_B, A_RD_OUT,
        A_SEEN_CLR, A_PS_END, A_PS_LADDR, A_PS_LB, A_PS_SKIP,
        A_PS_GSTART, A_PS_GDONE, A_GATHER, A_PS_INEXT,
        A_PS_XY, A_PS_JNEXT, A_PS_IDX, A_PS_EMIT, A_PUSH
    } t_act;

    typedef struct packed {
        t_act act;
        logic push;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic live;
        logic key_eq;
        logic act_full;
        logic probe_last;
        logic k_end;
        logic obj_eq;
        logic pool_full;
        logic slot_ok;
        logic slot_end;
        logic cnt_lt2;
        logic gathered;
        logic g_end;
        logic i_end;
        logic j_end;
        logic xy_same;
        logic seen_hit;
        logic tsw_last;
        logic ssw_last;
        logic gen_wrap;
        logic running;
    } t_sts;

    typedef struct packed {
        t_status     status;
        logic [9:0]  bucket_index;
        logic [15:0] cell_x;
        logic [15:0] cell_y;
        logic [15:0] cell_z;
        logic [12:0] cell_count;
        logic        pair_valid;
        logic [7:0]  pair_first;
        logic [7:0]  pair_second;
        logic        pairs_done;
    } t_res;

endpackage

/* hw/rtl/shbt_ctrl.sv */
// Controller state machine of the spatial hash broadphase table.
// Depends on shbt_pkg; drives shbt_dp through a command struct.
module shbt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_in_op,
    input  logic           i_out_free,
    input  shbt_pkg::t_sts i_sts,
    output shbt_pkg::t_cmd o_cmd
);

    shbt_pkg::t_state r_state;
    shbt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shbt_pkg::S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.act      = shbt_pkg::A_IDLE;
        o_cmd.push     = 1'b0;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            shbt_pkg::S_BOOT: begin
                o_cmd.act = shbt_pkg::A_TSWEEP;
                if (i_sts.tsw_last) n_state = shbt_pkg::S_IDLE;
            end
            shbt_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.act = shbt_pkg::A_LOAD;
                    case (i_in_op)
                        shbt_pkg::OP_CLEAR:  n_state = shbt_pkg::S_CLEAR;
                        shbt_pkg::OP_INSERT: n_state = shbt_pkg::S_MUL0;
                        shbt_pkg::OP_READ:   n_state = shbt_pkg::S_RD_LIST;
                        default: n_state = i_sts.running ? shbt_pkg::S_PS_SLOT
                                                         : shbt_pkg::S_PS_CLR;
                    endcase
                end
            end
            shbt_pkg::S_CLEAR: begin
                o_cmd.act = shbt_pkg::A_CLEAR;
                n_state = i_sts.gen_wrap ? shbt_pkg::S_WRAP : shbt_pkg::S_DONE;
            end
            shbt_pkg::S_WRAP: begin
                o_cmd.act = shbt_pkg::A_TSWEEP;
                if (i_sts.tsw_last) n_state = shbt_pkg::S_DONE;
            end
            shbt_pkg::S_MUL0: begin
                o_cmd.act = shbt_pkg::A_MUL0;
                n_state = shbt_pkg::S_MUL1;
            end
            shbt_pkg::S_MUL1: begin
                o_cmd.act = shbt_pkg::A_MUL1;
                n_state = shbt_pkg::S_MUL2;
            end
            shbt_pkg::S_MUL2: begin
                o_cmd.act = shbt_pkg::A_MUL2;
                n_state = shbt_pkg::S_PRB_SET;
            end
            shbt_pkg::S_PRB_SET: begin
                o_cmd.act = shbt_pkg::A_PRB_SET;
                n_state = shbt_pkg::S_PRB_RD;
            end
            shbt_pkg::S_PRB_RD: begin
                n_state = shbt_pkg::S_PRB_CHK;
            end
            shbt_pkg::S_PRB_CHK: begin
                if (!i_sts.live) begin
                    if (i_sts.act_full) begin
                        o_cmd.act = shbt_pkg::A_TFULL;
                        n_state = shbt_pkg::S_DONE;
                    end else begin
                        o_cmd.act = shbt_pkg::A_CLAIM;
                        n_state = shbt_pkg::S_ADD;
                    end
                end else if (i_sts.key_eq) begin
                    o_cmd.act = shbt_pkg::A_FOUND;
                    n_state = shbt_pkg::S_DUP;
                end else if (i_sts.probe_last) begin
                    o_cmd.act = shbt_pkg::A_TFULL;
                    n_state = shbt_pkg::S_DONE;
                end else begin
                    o_cmd.act = shbt_pkg::A_PRB_NEXT;
                    n_state = shbt_pkg::S_PRB_RD;
                end
            end
            shbt_pkg::S_DUP: begin
                n_state = i_sts.k_end ? shbt_pkg::S_ADD : shbt_pkg::S_DUP_CHK;
            end
            shbt_pkg::S_DUP_CHK: begin
                if (i_sts.obj_eq) begin
                    o_cmd.act = shbt_pkg::A_DUP;
                    n_state = shbt_pkg::S_DONE;
                end else begin
                    o_cmd.act = shbt_pkg::A_DUP_NEXT;
                    n_state = shbt_pkg::S_DUP;
                end
            end
            shbt_pkg::S_ADD: begin
                o_cmd.act = i_sts.pool_full ? shbt_pkg::A_POOLFULL : shbt_pkg::A_ADD;
                n_state = shbt_pkg::S_DONE;
            end
            shbt_pkg::S_RD_LIST: begin
                if (i_sts.slot_ok) begin
                    n_state = shbt_pkg::S_RD_BKT;
                end else begin
                    o_cmd.act = shbt_pkg::A_RD_BAD;
                    n_state = shbt_pkg::S_DONE;
                end
            end
            shbt_pkg::S_RD_BKT: begin
                o_cmd.act = shbt_pkg::A_RD_B;
                n_state = shbt_pkg::S_RD_WAIT;
            end
            shbt_pkg::S_RD_WAIT: begin
                n_state = shbt_pkg::S_RD_OUT;
            end
            shbt_pkg::S_RD_OUT: begin
                o_cmd.act = shbt_pkg::A_RD_OUT;
                n_state = shbt_pkg::S_DONE;
            end
            shbt_pkg::S_PS_CLR: begin
                o_cmd.act = shbt_pkg::A_SEEN_CLR;
                if (i_sts.ssw_last) n_state = shbt_pkg::S_PS_SLOT;
            end
            shbt_pkg::S_PS_SLOT: begin
                if (i_sts.slot_end) begin
                    o_cmd.act = shbt_pkg::A_PS_END;
                    n_state = shbt_pkg::S_DONE;
                end else if (i_sts.gathered) begin
                    n_state = shbt_pkg::S_PS_PAIR;
                end else begin
                    o_cmd.act = shbt_pkg::A_PS_LADDR;
                    n_state = shbt_pkg::S_PS_LW;
                end
            end
            shbt_pkg::S_PS_LW: begin
                n_state = shbt_pkg::S_PS_LB;
            end
            shbt_pkg::S_PS_LB: begin
                o_cmd.act = shbt_pkg::A_PS_LB;
                n_state = shbt_pkg::S_PS_BW;
            end
            shbt_pkg::S_PS_BW: begin
                n_state = shbt_pkg::S_PS_BCHK;
            end
            shbt_pkg::S_PS_BCHK: begin
                if (i_sts.cnt_lt2) begin
                    o_cmd.act = shbt_pkg::A_PS_SKIP;
                    n_state = shbt_pkg::S_PS_SLOT;
                end else begin
                    o_cmd.act = shbt_pkg::A_PS_GSTART;
                    n_state = shbt_pkg::S_PS_GW;
                end
            end
            shbt_pkg::S_PS_GW: begin
                if (i_sts.g_end) begin
                    o_cmd.act = shbt_pkg::A_PS_GDONE;
                    n_state = shbt_pkg::S_PS_PAIR;
                end else begin
                    n_state = shbt_pkg::S_PS_G;
                end
            end
            shbt_pkg::S_PS_G: begin
                o_cmd.act = shbt_pkg::A_GATHER;
                n_state = shbt_pkg::S_PS_GW;
            end
            shbt_pkg::S_PS_PAIR: begin
                if (i_sts.i_end) begin
                    o_cmd.act = shbt_pkg::A_PS_SKIP;
                    n_state = shbt_pkg::S_PS_SLOT;
                end else if (i_sts.j_end) begin
                    o_cmd.act = shbt_pkg::A_PS_INEXT;
                end else begin
                    n_state = shbt_pkg::S_PS_XY;
                end
            end
            shbt_pkg::S_PS_XY: begin
                o_cmd.act = shbt_pkg::A_PS_XY;
                n_state = i_sts.xy_same ? shbt_pkg::S_PS_PAIR : shbt_pkg::S_PS_IDX;
            end
            shbt_pkg::S_PS_IDX: begin
                o_cmd.act = shbt_pkg::A_PS_IDX;
                n_state = shbt_pkg::S_PS_SW;
            end
            shbt_pkg::S_PS_SW: begin
                n_state = shbt_pkg::S_PS_SCHK;
            end
            shbt_pkg::S_PS_SCHK: begin
                if (i_sts.seen_hit) begin
                    o_cmd.act = shbt_pkg::A_PS_JNEXT;
                    n_state = shbt_pkg::S_PS_PAIR;
                end else begin
                    o_cmd.act = shbt_pkg::A_PS_EMIT;
                    n_state = shbt_pkg::S_DONE;
                end
            end
            shbt_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_cmd.act  = shbt_pkg::A_PUSH;
                    o_cmd.push = 1'b1;
                    n_state = shbt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shbt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/shbt_dp.sv */
// Datapath of the spatial hash broadphase table: bucket, entry, activation,
// gather and pair-seen memories, hash multiplier and cursors. Uses shbt_pkg.
module shbt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  shbt_pkg::t_cmd                i_cmd,
    input  logic [shbt_pkg::InDataW-1:0]  i_in_data,
    input  logic [1:0]                    i_in_op,
    output shbt_pkg::t_sts                o_sts,
    output shbt_pkg::t_res                o_res,
    output logic [10:0]                   o_active_count
);

    // Bucket memories
    logic [32:0] m_tag  [0:1023];
    logic [63:0] m_key  [0:1023];
    logic [11:0] m_head [0:1023];
    logic [12:0] m_cnt  [0:1023];
    logic [47:0] m_cell [0:1023];
    logic [9:0]  m_alist[0:1023];
    // Entry pool and gather buffer
    logic [7:0]  m_eobj [0:4095];
    logic [11:0] m_elink[0:4095];
    logic [7:0]  m_gath [0:4095];
    // Pair dedup bitset
    logic [63:0] m_seen [0:511];

    logic [32:0] r_tag_q;
    logic [63:0] r_key_q;
    logic [11:0] r_head_q;
    logic [12:0] r_cnt_q;
    logic [47:0] r_cell_q;
    logic [9:0]  r_alist_q;
    logic [7:0]  r_eobj_q;
    logic [11:0] r_elink_q;
    logic [7:0]  r_gi_q;
    logic [7:0]  r_gj_q;
    logic [63:0] r_seen_q;

    logic [31:0] r_gen;
    logic [10:0] r_act;
    logic [12:0] r_pool;
    logic        r_run;
    logic [9:0]  r_tsw;
    logic [8:0]  r_ssw;
    logic        r_gath;

    logic [7:0]  r_obj;
    logic [47:0] r_cell;
    logic [63:0] r_key;
    logic [9:0]  r_baddr;
    logic [9:0]  r_probes;
    logic [11:0] r_head;
    logic [12:0] r_cnt;
    logic [11:0] r_eaddr;
    logic [12:0] r_k;
    logic [9:0]  r_laddr;
    logic [10:0] r_pslot;
    logic [12:0] r_pi;
    logic [12:0] r_pj;
    logic [12:0] r_pn;
    logic [9:0]  r_pbkt;
    logic [7:0]  r_px;
    logic [7:0]  r_py;
    logic [14:0] r_pidx;
    shbt_pkg::t_res r_res;

    shbt_pkg::t_act act;
    assign act = i_cmd.act;

    // Shared hash multiplier
    logic signed [15:0] mul_a;
    logic        [26:0] mul_c;
    logic signed [43:0] prod;
    logic        [63:0] prod_ext;

    always_comb begin
        case (act)
            shbt_pkg::A_MUL1: begin
                mul_a = $signed(r_cell[31:16]);
                mul_c = shbt_pkg::HashY;
            end
            shbt_pkg::A_MUL2: begin
                mul_a = $signed(r_cell[47:32]);
                mul_c = shbt_pkg::HashZ;
            end
            default: begin
                mul_a = $signed(r_cell[15:0]);
                mul_c = shbt_pkg::HashX;
            end
        endcase
    end

    assign prod     = mul_a * $signed({1'b0, mul_c});
    assign prod_ext = {{20{prod[43]}}, prod};

    logic [15:0] tri_prod;
    assign tri_prod = {8'd0, r_py} * ({8'd0, r_py} - 16'd1);

    // Memory write controls
    logic        tag_we;
    logic [9:0]  tag_wa;
    logic [32:0] tag_wd;
    logic        claim;
    logic        add;
    logic        seen_we;
    logic [8:0]  seen_wa;
    logic [63:0] seen_wd;

    assign claim   = (act == shbt_pkg::A_CLAIM);
    assign add     = (act == shbt_pkg::A_ADD);
    assign tag_we  = claim || (act == shbt_pkg::A_TSWEEP);
    assign tag_wa  = claim ? r_baddr : r_tsw;
    assign tag_wd  = claim ? {1'b1, r_gen} : 33'd0;
    assign seen_we = (act == shbt_pkg::A_SEEN_CLR) || (act == shbt_pkg::A_PS_EMIT);
    assign seen_wa = (act == shbt_pkg::A_SEEN_CLR) ? r_ssw : r_pidx[14:6];
    assign seen_wd = (act == shbt_pkg::A_SEEN_CLR) ? 64'd0
                   : (r_seen_q | (64'd1 << r_pidx[5:0]));

    always_ff @(posedge i_clk) begin
        if (tag_we) m_tag[tag_wa] <= tag_wd;
        r_tag_q <= m_tag[r_baddr];
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            m_key[r_baddr]  <= r_key;
            m_cell[r_baddr] <= r_cell;
        end
        r_key_q  <= m_key[r_baddr];
        r_cell_q <= m_cell[r_baddr];
    end

    always_ff @(posedge i_clk) begin
        if (claim || add) begin
            m_head[r_baddr] <= claim ? 12'd0 : r_pool[11:0];
            m_cnt[r_baddr]  <= claim ? 13'd0 : r_cnt + 13'd1;
        end
        r_head_q <= m_head[r_baddr];
        r_cnt_q  <= m_cnt[r_baddr];
    end

    always_ff @(posedge i_clk) begin
        if (claim) m_alist[r_act[9:0]] <= r_baddr;
        r_alist_q <= m_alist[r_laddr];
    end

    always_ff @(posedge i_clk) begin
        if (add) begin
            m_eobj[r_pool[11:0]]  <= r_obj;
            m_elink[r_pool[11:0]] <= r_head;
        end
        r_eobj_q  <= m_eobj[r_eaddr];
        r_elink_q <= m_elink[r_eaddr];
    end

    always_ff @(posedge i_clk) begin
        if (act == shbt_pkg::A_GATHER) m_gath[r_k[11:0]] <= r_eobj_q;
        r_gi_q <= m_gath[r_pi[11:0]];
        r_gj_q <= m_gath[r_pj[11:0]];
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) m_seen[seen_wa] <= seen_wd;
        r_seen_q <= m_seen[r_pidx[14:6]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= '0;
            r_act  <= '0;
            r_pool <= '0;
            r_run  <= 1'b0;
            r_tsw  <= '0;
            r_ssw  <= '0;
            r_gath <= 1'b0;
        end else begin
            case (act)
                shbt_pkg::A_TSWEEP:   r_tsw <= r_tsw + 10'd1;
                shbt_pkg::A_LOAD: begin
                    if (i_in_op == shbt_pkg::OP_INSERT) r_run <= 1'b0;
                end
                shbt_pkg::A_CLEAR: begin
                    r_gen  <= r_gen + 32'd1;
                    r_act  <= '0;
                    r_pool <= '0;
                    r_run  <= 1'b0;
                end
                shbt_pkg::A_CLAIM:    r_act  <= r_act + 11'd1;
                shbt_pkg::A_ADD:      r_pool <= r_pool + 13'd1;
                shbt_pkg::A_SEEN_CLR: begin
                    r_ssw  <= r_ssw + 9'd1;
                    r_run  <= 1'b1;
                    r_gath <= 1'b0;
                end
                shbt_pkg::A_PS_END:   r_run  <= 1'b0;
                shbt_pkg::A_PS_SKIP:  r_gath <= 1'b0;
                shbt_pkg::A_PS_GDONE: r_gath <= 1'b1;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (act)
            shbt_pkg::A_LOAD: begin
                r_obj   <= i_in_data[7:0];
                r_cell  <= i_in_data[55:8];
                r_laddr <= i_in_data[65:56];
                r_res   <= '0;
            end
            shbt_pkg::A_CLEAR:  r_res <= '0;
            shbt_pkg::A_MUL0:   r_key <= prod_ext;
            shbt_pkg::A_MUL1:   r_key <= r_key ^ prod_ext;
            shbt_pkg::A_MUL2:   r_key <= r_key ^ prod_ext;
            shbt_pkg::A_PRB_SET: begin
                r_baddr  <= r_key[9:0];
                r_probes <= '0;
            end
            shbt_pkg::A_PRB_NEXT: begin
                r_baddr  <= r_baddr + 10'd1;
                r_probes <= r_probes + 10'd1;
            end
            shbt_pkg::A_CLAIM: begin
                r_head             <= '0;
                r_cnt              <= '0;
                r_res.bucket_index <= r_baddr;
            end
            shbt_pkg::A_FOUND: begin
                r_head             <= r_head_q;
                r_cnt              <= r_cnt_q;
                r_eaddr            <= r_head_q;
                r_k                <= '0;
                r_res.bucket_index <= r_baddr;
            end
            shbt_pkg::A_TFULL:    r_res.status <= shbt_pkg::ST_TABLE_FULL;
            shbt_pkg::A_DUP_NEXT: begin
                r_eaddr <= r_elink_q;
                r_k     <= r_k + 13'd1;
            end
            shbt_pkg::A_DUP:      r_res.status <= shbt_pkg::ST_DUP;
            shbt_pkg::A_POOLFULL: r_res.status <= shbt_pkg::ST_POOL_FULL;
            shbt_pkg::A_RD_BAD:   r_res.status <= shbt_pkg::ST_NO_SLOT;
            shbt_pkg::A_RD_B:     r_baddr <= r_alist_q;
            shbt_pkg::A_RD_OUT: begin
                r_res.bucket_index <= r_baddr;
                r_res.cell_x       <= r_cell_q[15:0];
                r_res.cell_y       <= r_cell_q[31:16];
                r_res.cell_z       <= r_cell_q[47:32];
                r_res.cell_count   <= r_cnt_q;
            end
            shbt_pkg::A_SEEN_CLR: begin
                r_pslot <= '0;
                r_pi    <= '0;
                r_pj    <= 13'd1;
            end
            shbt_pkg::A_PS_END:   r_res.pairs_done <= 1'b1;
            shbt_pkg::A_PS_LADDR: r_laddr <= r_pslot[9:0];
            shbt_pkg::A_PS_LB:    r_baddr <= r_alist_q;
            shbt_pkg::A_PS_SKIP: begin
                r_pslot <= r_pslot + 11'd1;
                r_pi    <= '0;
                r_pj    <= 13'd1;
            end
            shbt_pkg::A_PS_GSTART: begin
                r_pn    <= r_cnt_q;
                r_eaddr <= r_head_q;
                r_k     <= '0;
                r_pbkt  <= r_baddr;
            end
            shbt_pkg::A_GATHER: begin
                r_eaddr <= r_elink_q;
                r_k     <= r_k + 13'd1;
            end
            shbt_pkg::A_PS_INEXT: begin
                r_pi <= r_pi + 13'd1;
                r_pj <= r_pi + 13'd2;
            end
            shbt_pkg::A_PS_XY: begin
                if (r_gi_q == r_gj_q) begin
                    r_pj <= r_pj + 13'd1;
                end else if (r_gi_q < r_gj_q) begin
                    r_px <= r_gi_q;
                    r_py <= r_gj_q;
                end else begin
                    r_px <= r_gj_q;
                    r_py <= r_gi_q;
                end
            end
            shbt_pkg::A_PS_JNEXT: r_pj <= r_pj + 13'd1;
            shbt_pkg::A_PS_IDX:   r_pidx <= tri_prod[15:1] + {7'd0, r_px};
            shbt_pkg::A_PS_EMIT: begin
                r_pj               <= r_pj + 13'd1;
                r_res.pair_valid   <= 1'b1;
                r_res.pair_first   <= r_px;
                r_res.pair_second  <= r_py;
                r_res.bucket_index <= r_pbkt;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.live       = r_tag_q[32] && (r_tag_q[31:0] == r_gen);
        o_sts.key_eq     = (r_key_q == r_key);
        o_sts.act_full   = r_act[10];
        o_sts.probe_last = &r_probes;
        o_sts.k_end      = (r_k == r_cnt);
        o_sts.obj_eq     = (r_eobj_q == r_obj);
        o_sts.pool_full  = r_pool[12];
        o_sts.slot_ok    = ({1'b0, r_laddr} < r_act);
        o_sts.slot_end   = (r_pslot >= r_act);
        o_sts.cnt_lt2    = (r_cnt_q < 13'd2);
        o_sts.gathered   = r_gath;
        o_sts.g_end      = (r_k == r_pn);
        o_sts.i_end      = !(({1'b0, r_pi} + 14'd1) < {1'b0, r_pn});
        o_sts.j_end      = (r_pj >= r_pn);
        o_sts.xy_same    = (r_gi_q == r_gj_q);
        o_sts.seen_hit   = r_seen_q[r_pidx[5:0]];
        o_sts.tsw_last   = &r_tsw;
        o_sts.ssw_last   = &r_ssw;
        o_sts.gen_wrap   = &r_gen;
        o_sts.running    = r_run;
    end

    assign o_res          = r_res;
    assign o_active_count = r_act;

endmodule

/* hw/rtl/spatial_hash_broadphase_table.sv */
// Top level of the spatial hash broadphase table: stream ports, output
// register, controller (shbt_ctrl) and datapath (shbt_dp). Uses shbt_pkg.
//
// Usage: each input transaction carries one command in s_axis_tuser (clear,
// insert, read active cell, pair step) and its operands in s_axis_tdata.
// Every command returns exactly one output transaction on m_axis.
// Commands are processed one at a time. An insert walks the probes of the
// bucket table and compares the chain entries of the bucket it finds. A
// pair step visits buckets, gathers their chain entries and tests pairs,
// skipping a pair whose two objects are equal; the first step of a pass
// also clears the 512-word dedup bitset, one word per cycle.
// After reset the block sweeps the 1024 bucket tags, one per cycle, and
// holds s_axis_tready low until that is done. A clear that wraps the 32-bit
// generation repeats the same sweep. The result sits in an output
// register; while the receiver stalls, the next command can still be taken,
// and its result waits until the register is free.
module spatial_hash_broadphase_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // fields from bit 0: object_index, cell_x, cell_y, cell_z, active_slot
    input  logic [shbt_pkg::InDataW-1:0]  s_axis_tdata,
    // fields from bit 0: opcode
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // fields from bit 0: status, bucket_index, active_count, out_cell_x,
    // out_cell_y, out_cell_z, cell_object_count, pair_valid, pair_first,
    // pair_second, pairs_done
    output logic [shbt_pkg::OutDataW-1:0] m_axis_tdata
);

    shbt_pkg::t_cmd cmd;
    shbt_pkg::t_sts sts;
    shbt_pkg::t_res res;
    logic [10:0]    active_count;

    logic                          r_mvalid;
    logic [shbt_pkg::OutDataW-1:0] r_mdata;
    logic                          out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_mvalid || m_axis_tready;

    shbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    shbt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_data      (s_axis_tdata),
        .i_in_op        (s_axis_tuser),
        .o_sts          (sts),
        .o_res          (res),
        .o_active_count (active_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (cmd.push) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.push) begin
            r_mdata <= {1'b0, res.pairs_done, res.pair_second, res.pair_first,
                        res.pair_valid, res.cell_count, res.cell_z, res.cell_y,
                        res.cell_x, active_count, res.bucket_index, res.status};
        end
    end

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

/* hw/rtl/shbt_chk.sv */
// Port-level checker for the spatial hash broadphase table, bound to the
// top level. Uses shbt_pkg for the data widths.
module shbt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [shbt_pkg::OutDataW-1:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    // One command at a time: after a transaction the input side closes.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in back-to-back cycles");

    // A pair step never reports a pair and the end of the pass together.
    a_pair_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[85] && m_axis_tdata[102]))
        else $error("pair_valid and pairs_done both set");

    // An emitted pair is ordered with distinct objects.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[85] |-> m_axis_tdata[93:86] < m_axis_tdata[101:94])
        else $error("emitted pair not ordered");

endmodule

bind spatial_hash_broadphase_table shbt_chk u_shbt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/testbench.sv */
// Self-checking bench for the spatial hash broadphase table (clear, insert,
// read active cell, pair step). Depends on shbt_pkg and the top level only;
// a scoreboard class predicts every result and checks the output stream.

// Expected or observed result, laid out as the output tdata from bit 102 down.
typedef struct packed {
    logic        pairs_done;
    logic [7:0]  pair_second;
    logic [7:0]  pair_first;
    logic        pair_valid;
    logic [12:0] object_count;
    logic [15:0] cell_z;
    logic [15:0] cell_y;
    logic [15:0] cell_x;
    logic [10:0] active_count;
    logic [9:0]  bucket_index;
    logic [2:0]  status;
} t_cell_result;

class t_broadphase_scoreboard;
    localparam int Buckets = 1024;
    localparam int Pool    = 4096;
    localparam int SeenW   = 510;

    logic [63:0] bkt_key[Buckets];
    logic [31:0] bkt_tag[Buckets];
    bit          bkt_valid[Buckets];
    int unsigned bkt_head[Buckets];
    int unsigned bkt_count[Buckets];
    logic [47:0] bkt_xyz[Buckets];
    int unsigned ent_obj[Pool];
    int unsigned ent_link[Pool];
    int unsigned claim_order[Buckets];
    int unsigned chain[Pool];
    logic [63:0] seen[SeenW];
    logic [31:0] gen;
    int unsigned pool_used, active_total;
    bit          pass_running;
    int unsigned walk_slot, walk_i, walk_j;
    t_cell_result pending[$];
    int errors, reported;

    function new();
        for (int b = 0; b < Buckets; b++) begin
            bkt_valid[b] = 0;
            bkt_tag[b] = '0;
        end
        gen = '0;
        pool_used = 0;
        active_total = 0;
        pass_running = 0;
        errors = 0;
        reported = 0;
    endfunction

    function bit live(int unsigned b);
        return bkt_valid[b] && bkt_tag[b] == gen;
    endfunction

    function int unsigned gather(int unsigned b);
        int unsigned n, cur;
        n = 0;
        cur = bkt_head[b];
        for (int k = 0; k < bkt_count[b]; k++) begin
            chain[n++] = ent_obj[cur];
            cur = ent_link[cur];
        end
        return n;
    endfunction

    // Advances the pair walk; returns 1 with the next unseen ordered pair.
    function bit next_pair(output int unsigned b, output int unsigned pa,
                           output int unsigned pb);
        int unsigned n, i, j, x, y, idx;
        while (walk_slot < active_total) begin
            b = claim_order[walk_slot];
            if (live(b) && bkt_count[b] >= 2) begin
                n = gather(b);
                i = walk_i;
                j = walk_j;
                while (i + 1 < n) begin
                    if (j <= i) j = i + 1;
                    for (; j < n; j++) begin
                        x = chain[i];
                        y = chain[j];
                        if (x == y) continue;
                        if (x > y) begin
                            x = chain[j];
                            y = chain[i];
                        end
                        idx = y * (y - 1) / 2 + x;
                        if ((idx >> 6) >= SeenW) continue;
                        if (seen[idx >> 6][idx & 63]) continue;
                        seen[idx >> 6][idx & 63] = 1'b1;
                        walk_i = i;
                        walk_j = j + 1;
                        pa = x;
                        pb = y;
                        return 1;
                    end
                    i++;
                    j = i + 1;
                end
            end
            walk_slot++;
            walk_i = 0;
            walk_j = 1;
        end
        return 0;
    endfunction

    // Updates the model for one accepted command and queues its result.
    function t_cell_result note(shbt_pkg::t_op op, logic [7:0] obj, logic [15:0] x,
                                logic [15:0] y, logic [15:0] z, logic [9:0] slot);
        t_cell_result r;
        logic [63:0] key;
        int unsigned b, idx, cur, pa, pb;
        bit found, dup;
        r = '0;
        case (op)
            shbt_pkg::OP_CLEAR: begin
                gen = gen + 1;
                if (gen == 0)
                    for (int k = 0; k < Buckets; k++) bkt_valid[k] = 0;
                pool_used = 0;
                active_total = 0;
                pass_running = 0;
            end
            shbt_pkg::OP_INSERT: begin
                pass_running = 0;
                key = ({{48{x[15]}}, x} * 64'd73856093) ^ ({{48{y[15]}}, y} * 64'd19349663)
                    ^ ({{48{z[15]}}, z} * 64'd83492791);
                idx = key[9:0];
                found = 0;
                for (int p = 0; p < Buckets; p++) begin
                    if (!live(idx)) begin
                        if (active_total < Buckets) begin
                            bkt_valid[idx] = 1;
                            bkt_tag[idx] = gen;
                            bkt_key[idx] = key;
                            bkt_head[idx] = 0;
                            bkt_count[idx] = 0;
                            bkt_xyz[idx] = {z, y, x};
                            claim_order[active_total++] = idx;
                            found = 1;
                        end
                        break;
                    end
                    if (bkt_key[idx] == key) begin
                        found = 1;
                        break;
                    end
                    idx = (idx + 1) % Buckets;
                end
                if (!found) begin
                    r.status = shbt_pkg::ST_TABLE_FULL;
                end else begin
                    r.bucket_index = idx;
                    dup = 0;
                    cur = bkt_head[idx];
                    for (int k = 0; k < bkt_count[idx]; k++) begin
                        if (ent_obj[cur] == obj) begin
                            dup = 1;
                            break;
                        end
                        cur = ent_link[cur];
                    end
                    if (dup) begin
                        r.status = shbt_pkg::ST_DUP;
                    end else if (pool_used >= Pool) begin
                        r.status = shbt_pkg::ST_POOL_FULL;
                    end else begin
                        ent_obj[pool_used] = obj;
                        ent_link[pool_used] = bkt_head[idx];
                        bkt_head[idx] = pool_used;
                        pool_used++;
                        bkt_count[idx]++;
                    end
                end
            end
            shbt_pkg::OP_READ: begin
                if (slot < active_total) begin
                    b = claim_order[slot];
                    r.bucket_index = b;
                    {r.cell_z, r.cell_y, r.cell_x} = bkt_xyz[b];
                    r.object_count = bkt_count[b];
                end else begin
                    r.status = shbt_pkg::ST_NO_SLOT;
                end
            end
            default: begin
                if (!pass_running) begin
                    for (int k = 0; k < SeenW; k++) seen[k] = '0;
                    pass_running = 1;
                    walk_slot = 0;
                    walk_i = 0;
                    walk_j = 1;
                end
                if (next_pair(b, pa, pb)) begin
                    r.bucket_index = b;
                    r.pair_valid = 1;
                    r.pair_first = pa;
                    r.pair_second = pb;
                end else begin
                    r.pairs_done = 1;
                    pass_running = 0;
                end
            end
        endcase
        r.active_count = active_total;
        pending.push_back(r);
        return r;
    endfunction

    function void field(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("mismatch on %s: expected %0d, got %0d", name, e, a);
            end
        end
    endfunction

    function void check(logic [shbt_pkg::OutDataW-1:0] d);
        t_cell_result e, a;
        a = d[102:0];
        if (pending.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("result with nothing pending: %h", d);
            end
            return;
        end
        e = pending.pop_front();
        field("status", e.status, a.status);
        field("bucket_index", e.bucket_index, a.bucket_index);
        field("active_count", e.active_count, a.active_count);
        field("cell_x", e.cell_x, a.cell_x);
        field("cell_y", e.cell_y, a.cell_y);
        field("cell_z", e.cell_z, a.cell_z);
        field("object_count", e.object_count, a.object_count);
        field("pair_valid", e.pair_valid, a.pair_valid);
        field("pair_first", e.pair_first, a.pair_first);
        field("pair_second", e.pair_second, a.pair_second);
        field("pairs_done", e.pairs_done, a.pairs_done);
    endfunction
endclass

module testbench;

    // Generous bound: the capacity phase probes a nearly full table.
    localparam int CycleLimit = 10000000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // object_index, cell_x, cell_y, cell_z, active_slot from bit 0
    logic [shbt_pkg::InDataW-1:0]  s_axis_tdata;
    // opcode
    logic [1:0]                    s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // status, bucket_index, active_count, cell x/y/z, object count,
    // pair_valid, pair_first, pair_second, pairs_done from bit 0
    logic [shbt_pkg::OutDataW-1:0] m_axis_tdata;

    t_broadphase_scoreboard sb;
    int  sent;
    int  taken;
    int  cycles;
    bit  calm;

    spatial_hash_broadphase_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Offers one command and waits for its transaction. Idle gaps come in
    // bursts, and only in alternating windows of 64 commands so that long
    // back-to-back stretches occur too. The model is updated on acceptance.
    task automatic send(input shbt_pkg::t_op op, input logic [7:0] obj,
                        input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z, input logic [9:0] slot,
                        output t_cell_result res);
        if (!calm && ((sent / 64) % 2 == 0) && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, slot, z, y, x, obj};
        do @(posedge i_clk); while (!s_axis_tready);
        res = sb.note(op, obj, x, y, z, slot);
        sent++;
    endtask

    // Any command with random operands, including the fields it ignores.
    task automatic send_any(input shbt_pkg::t_op op, output t_cell_result res);
        send(op, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             10'($urandom), res);
    endtask

    task automatic send_insert(input logic [7:0] obj, input logic [47:0] xyz,
                               output t_cell_result res);
        send(shbt_pkg::OP_INSERT, obj, xyz[15:0], xyz[31:16], xyz[47:32],
             10'($urandom), res);
    endtask

    // Steps a pair pass until it reports done, or gives up after a cap so a
    // later insert or clear abandons it.
    task automatic pair_pass(input int cap);
        t_cell_result r;
        for (int k = 0; k < cap; k++) begin
            send_any(shbt_pkg::OP_PAIR, r);
            if (r.pairs_done) break;
        end
    endtask

    // Receiver: random stall bursts, one long hold-off after the 200th
    // result so the output register and the input side both back up.
    initial begin
        int  stall;
        bit  pressed;
        stall = 0;
        pressed = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check(m_axis_tdata);
                taken++;
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (!pressed && taken >= 200) begin
                pressed = 1;
                stall = 499;
                m_axis_tready <= 1'b0;
            end else if (!calm && ((taken / 50) % 2 == 1) && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_cell_result r;
        logic [47:0]  cells[16];
        logic [7:0]   objs[16];
        int           ncells, nobjs, ninserts;

        sb = new();
        sent = 0;
        calm = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = shbt_pkg::OP_CLEAR;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, coordinate extremes, duplicates, a small
        // pair pass, a pass abandoned by an insert, reads in and out of range.
        send_any(shbt_pkg::OP_READ, r);
        send_any(shbt_pkg::OP_PAIR, r);
        send(shbt_pkg::OP_INSERT, 8'd0, 16'h8000, 16'h8000, 16'h8000, 10'd0, r);
        send(shbt_pkg::OP_INSERT, 8'd255, 16'h7fff, 16'h7fff, 16'h7fff, 10'h3ff, r);
        send(shbt_pkg::OP_INSERT, 8'd255, 16'h7fff, 16'h7fff, 16'h7fff, 10'd0, r);
        send(shbt_pkg::OP_INSERT, 8'd7, 16'h0, 16'h0, 16'h0, 10'd0, r);
        send(shbt_pkg::OP_INSERT, 8'd8, 16'h0, 16'h0, 16'h0, 10'd0, r);
        send(shbt_pkg::OP_INSERT, 8'd9, 16'h0, 16'h0, 16'h0, 10'd0, r);
        send(shbt_pkg::OP_INSERT, 8'd0, 16'h7fff, 16'h7fff, 16'h7fff, 10'd0, r);
        send(shbt_pkg::OP_READ, 8'd0, 16'h0, 16'h0, 16'h0, 10'd0, r);
        send(shbt_pkg::OP_READ, 8'd0, 16'h0, 16'h0, 16'h0, 10'd2, r);
        send(shbt_pkg::OP_READ, 8'd0, 16'h0, 16'h0, 16'h0, 10'd3, r);
        send(shbt_pkg::OP_READ, 8'd0, 16'h0, 16'h0, 16'h0, 10'h3ff, r);
        send_any(shbt_pkg::OP_PAIR, r);
        send_any(shbt_pkg::OP_PAIR, r);
        send(shbt_pkg::OP_INSERT, 8'd255, 16'h0, 16'h0, 16'h0, 10'd0, r);
        pair_pass(20);
        send_any(shbt_pkg::OP_PAIR, r);
        send_any(shbt_pkg::OP_CLEAR, r);
        send_any(shbt_pkg::OP_READ, r);
        send_any(shbt_pkg::OP_PAIR, r);

        // Capacity: 1024 new cells claim every bucket, one more finds the
        // table full, and an insert into the first cell still finds it.
        for (int c = 0; c < 1025; c++) begin
            cells[0] = {16'($urandom), 16'($urandom), 16'(c)};
            if (c == 0) cells[1] = cells[0];
            send_insert(8'($urandom), cells[0], r);
        end
        send_insert(8'($urandom), cells[1], r);
        send_any(shbt_pkg::OP_READ, r);
        send(shbt_pkg::OP_READ, 8'd0, 16'h0, 16'h0, 16'h0, 10'h3ff, r);
        send_any(shbt_pkg::OP_CLEAR, r);

        // Random phases: mostly well-formed fill / read / pair sequences over
        // a few cells and objects, with some noise and cut-short passes.
        while (sent < 1300) begin
            if (sent > 1200) calm = 1;
            if ($urandom_range(0, 3) != 0) send_any(shbt_pkg::OP_CLEAR, r);
            ncells = $urandom_range(1, 12);
            nobjs = $urandom_range(2, 16);
            for (int k = 0; k < ncells; k++)
                cells[k] = {16'($urandom), 16'($urandom), 16'($urandom)};
            for (int k = 0; k < nobjs; k++) objs[k] = 8'($urandom);
            ninserts = $urandom_range(4, 30);
            for (int k = 0; k < ninserts; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_any(shbt_pkg::t_op'($urandom_range(1, 3)), r);
                else
                    send_insert(objs[$urandom_range(0, nobjs - 1)],
                                cells[$urandom_range(0, ncells - 1)], r);
            end
            repeat ($urandom_range(1, 4))
                send(shbt_pkg::OP_READ, 8'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 10'($urandom_range(0, ncells + 1)), r);
            pair_pass($urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : 300);
        end

        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

/* spatial_hash_broadphase_table.f */
hw/rtl/shbt_pkg.sv
hw/rtl/shbt_ctrl.sv
hw/rtl/shbt_dp.sv
hw/rtl/spatial_hash_broadphase_table.sv
hw/rtl/shbt_chk.sv
bench/testbench.sv
